// ===== rtl/md5_hex_digest_top_macros.svh =====
// Assertion helpers for the asserting file, md5_hex_digest_top.sv.
`ifndef MD5_HEX_DIGEST_TOP_MACROS_SVH
`define MD5_HEX_DIGEST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MD5HD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MD5HD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/md5hd_pkg.sv =====
`default_nettype none
package md5hd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_RUN,
        ST_ADD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] CHAIN_A_INIT = 32'h67452301;
    localparam logic [31:0] CHAIN_B_INIT = 32'hefcdab89;
    localparam logic [31:0] CHAIN_C_INIT = 32'h98badcfe;
    localparam logic [31:0] CHAIN_D_INIT = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;
    localparam logic [5:0]  PAD_LIMIT    = 6'd56;
    localparam logic [5:0]  LAST_POS     = 6'd63;
    localparam logic [5:0]  LAST_STEP    = 6'd63;
    localparam logic [3:0]  LEN_WORD     = 4'd14;
    localparam logic [3:0]  LEN_HI_WORD  = 4'd15;
    localparam int          NUM_CHARS    = 32;
    localparam int          CHAR_CNT_W   = $clog2(NUM_CHARS);
    localparam logic [6:0]  ASCII_ZERO   = 7'h30;
    localparam logic [6:0]  ASCII_A_OFS  = 7'h57;

    function automatic logic [31:0] step_const(input logic [5:0] k);
        logic [31:0] v;
        begin
            case (k)
                6'd0:  v = 32'hd76aa478;  6'd1:  v = 32'he8c7b756;
                6'd2:  v = 32'h242070db;  6'd3:  v = 32'hc1bdceee;
                6'd4:  v = 32'hf57c0faf;  6'd5:  v = 32'h4787c62a;
                6'd6:  v = 32'ha8304613;  6'd7:  v = 32'hfd469501;
                6'd8:  v = 32'h698098d8;  6'd9:  v = 32'h8b44f7af;
                6'd10: v = 32'hffff5bb1;  6'd11: v = 32'h895cd7be;
                6'd12: v = 32'h6b901122;  6'd13: v = 32'hfd987193;
                6'd14: v = 32'ha679438e;  6'd15: v = 32'h49b40821;
                6'd16: v = 32'hf61e2562;  6'd17: v = 32'hc040b340;
                6'd18: v = 32'h265e5a51;  6'd19: v = 32'he9b6c7aa;
                6'd20: v = 32'hd62f105d;  6'd21: v = 32'h02441453;
                6'd22: v = 32'hd8a1e681;  6'd23: v = 32'he7d3fbc8;
                6'd24: v = 32'h21e1cde6;  6'd25: v = 32'hc33707d6;
                6'd26: v = 32'hf4d50d87;  6'd27: v = 32'h455a14ed;
                6'd28: v = 32'ha9e3e905;  6'd29: v = 32'hfcefa3f8;
                6'd30: v = 32'h676f02d9;  6'd31: v = 32'h8d2a4c8a;
                6'd32: v = 32'hfffa3942;  6'd33: v = 32'h8771f681;
                6'd34: v = 32'h6d9d6122;  6'd35: v = 32'hfde5380c;
                6'd36: v = 32'ha4beea44;  6'd37: v = 32'h4bdecfa9;
                6'd38: v = 32'hf6bb4b60;  6'd39: v = 32'hbebfbc70;
                6'd40: v = 32'h289b7ec6;  6'd41: v = 32'heaa127fa;
                6'd42: v = 32'hd4ef3085;  6'd43: v = 32'h04881d05;
                6'd44: v = 32'hd9d4d039;  6'd45: v = 32'he6db99e5;
                6'd46: v = 32'h1fa27cf8;  6'd47: v = 32'hc4ac5665;
                6'd48: v = 32'hf4292244;  6'd49: v = 32'h432aff97;
                6'd50: v = 32'hab9423a7;  6'd51: v = 32'hfc93a039;
                6'd52: v = 32'h655b59c3;  6'd53: v = 32'h8f0ccc92;
                6'd54: v = 32'hffeff47d;  6'd55: v = 32'h85845dd1;
                6'd56: v = 32'h6fa87e4f;  6'd57: v = 32'hfe2ce6e0;
                6'd58: v = 32'ha3014314;  6'd59: v = 32'h4e0811a1;
                6'd60: v = 32'hf7537e82;  6'd61: v = 32'hbd3af235;
                6'd62: v = 32'h2ad7d2bb;  6'd63: v = 32'heb86d391;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] k);
        logic [4:0] s;
        begin
            case ({k[5:4], k[1:0]})
                4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
                4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // Message word selected by each step; only k mod 16 matters inside a round.
    function automatic logic [3:0] msg_index(input logic [5:0] k);
        logic [3:0] kk;
        logic [3:0] g;
        begin
            kk = k[3:0];
            case (k[5:4])
                2'd0:    g = kk;
                2'd1:    g = 4'(kk * 4'd5 + 4'd1);
                2'd2:    g = 4'(kk * 4'd3 + 4'd5);
                default: g = 4'(kk * 4'd7);
            endcase
            return g;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            case (rnd)
                2'd0:    f = (b & c) | (~b & d);
                2'd1:    f = (b & d) | (c & ~d);
                2'd2:    f = b ^ c ^ d;
                default: f = c ^ (b | ~d);
            endcase
            return f;
        end
    endfunction

    function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
        logic [6:0] ch;
        begin
            if (nib < 4'd10) begin
                ch = ASCII_ZERO + 7'(nib);
            end else begin
                ch = ASCII_A_OFS + 7'(nib);
            end
            return ch;
        end
    endfunction

    // First emitted byte ends up in the top bits: a, b, c, d, each little-endian.
    function automatic logic [127:0] digest_order(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [31:0] c, input logic [31:0] d);
        logic [127:0] v;
        logic [127:0] w;
        begin
            w = {d, c, b, a};
            v = '0;
            for (int i = 0; i < 16; i++) begin
                v[127 - 8*i -: 8] = w[8*i +: 8];
            end
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/md5hd_step.sv =====
`default_nettype none
module md5hd_step
    import md5hd_pkg::*;
(
    input  wire logic [5:0]  i_k,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_c,
    input  wire logic [31:0] i_d,
    input  wire logic [31:0] i_w,
    input  wire logic [31:0] i_sum,
    output logic      [31:0] o_sum,
    output logic      [31:0] o_b
);

    logic [31:0] tmp;
    logic [63:0] rot_wide;

    // first half of a step: a + M[g] + K[k]
    assign o_sum = i_a + i_w + step_const(i_k);

    // second half: b + rotl(sum + F, s)
    assign tmp      = i_sum + round_f(i_k[5:4], i_b, i_c, i_d);
    assign rot_wide = {tmp, tmp} << rot_amount(i_k);
    assign o_b      = i_b + rot_wide[63:32];

endmodule
`default_nettype wire

// ===== rtl/md5hd_hex.sv =====
`default_nettype none
module md5hd_hex
    import md5hd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_load,
    input  wire logic [127:0] i_digest,
    output logic              o_busy,
    output logic              o_tvalid,
    input  wire logic         i_tready,
    output logic      [6:0]   o_char,
    output logic              o_tlast
);

    logic                  r_busy, n_busy;
    logic [CHAR_CNT_W-1:0] r_cnt, n_cnt;
    logic [127:0]          r_buf, n_buf;
    logic                  last;

    assign last     = (r_cnt == CHAR_CNT_W'(NUM_CHARS - 1));
    assign o_busy   = r_busy;
    assign o_tvalid = r_busy;
    assign o_tlast  = last;
    assign o_char   = hex_ascii(r_buf[127:124]);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_buf  = r_buf;
        if (i_load) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_buf  = i_digest;
        end else if (r_busy && i_tready) begin
            // advance one nibble per taken item
            n_buf = r_buf << 4;
            n_cnt = r_cnt + 1'b1;
            if (last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_buf <= n_buf;
    end

endmodule
`default_nettype wire

// ===== rtl/md5_hex_digest_top.sv =====
// A byte that does not fill the block is taken with no hold-off; a byte that fills it holds
// the input off for the 64 steps (each a sum phase, then a rotate phase, on the shared step
// unit) and the chain update, so a long message waits on each block's compression in turn.
// Final byte: compress first if it fills its block, pad, compress again if the length no
// longer fits, length, last compression, hand-over, then 32 items, one per cycle unless stalled.
// Reset: synchronous, active low; chaining words return to the MD5 IV, buffer and count clear.
`default_nettype none
module md5_hex_digest_top
    import md5hd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // slave side: message bytes
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,  // [7:0] msg_byte
    input  wire logic       i_s_axis_tlast,  // final_byte
    // master side: digest characters
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic      [7:0] o_m_axis_tdata,  // [6:0] hex_char, [7] zero
    output logic            o_m_axis_tlast   // last_char
);

    t_state       r_state, n_state;
    logic [28:0]  r_cnt, n_cnt;
    logic [5:0]   r_k, n_k;
    logic         r_ph, n_ph;
    logic         r_last, n_last;
    logic         r_pad_done, n_pad_done;
    logic         r_len_done, n_len_done;

    logic [31:0]  r_words [16];
    logic [31:0]  r_ca, r_cb, r_cc, r_cd;
    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [31:0]  r_sum;

    logic         accept;
    logic         byte_we;
    logic [7:0]   byte_val;
    logic [5:0]   pos;
    logic         len_we;
    logic         start;
    logic         add_en;
    logic         load;
    logic         hex_busy;
    logic [31:0]  step_sum;
    logic [31:0]  step_b;
    logic [6:0]   hex_char;

    assign pos             = r_cnt[5:0];
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tdata  = {1'b0, hex_char};

    // sequencer: next state and strobes
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_ph       = r_ph;
        n_last     = r_last;
        n_pad_done = r_pad_done;
        n_len_done = r_len_done;
        byte_we    = 1'b0;
        byte_val   = i_s_axis_tdata;
        len_we     = 1'b0;
        start      = 1'b0;
        add_en     = 1'b0;
        load       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    byte_we = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_last  = i_s_axis_tlast;
                    if (pos == LAST_POS) begin
                        start   = 1'b1;
                        n_state = ST_RUN;
                    end else if (i_s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // place the pad byte; compress first if the length no longer fits
                byte_we    = 1'b1;
                byte_val   = PAD_BYTE;
                n_pad_done = 1'b1;
                if (pos >= PAD_LIMIT) begin
                    start   = 1'b1;
                    n_state = ST_RUN;
                end else begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                len_we     = 1'b1;
                n_len_done = 1'b1;
                start      = 1'b1;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                // each step as a sum phase, then a rotate-and-shuffle phase
                n_ph = ~r_ph;
                if (r_ph) begin
                    n_k = r_k + 1'b1;
                    if (r_k == LAST_STEP) begin
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                add_en = 1'b1;
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (!r_pad_done) begin
                    n_state = ST_PAD;
                end else if (!r_len_done) begin
                    n_state = ST_LEN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hand the digest over once the previous one has drained, then start afresh
                if (!hex_busy) begin
                    load       = 1'b1;
                    n_cnt      = '0;
                    n_last     = 1'b0;
                    n_pad_done = 1'b0;
                    n_len_done = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (start) begin
            n_k  = '0;
            n_ph = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_k        <= '0;
            r_ph       <= 1'b0;
            r_last     <= 1'b0;
            r_pad_done <= 1'b0;
            r_len_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_k        <= n_k;
            r_ph       <= n_ph;
            r_last     <= n_last;
            r_pad_done <= n_pad_done;
            r_len_done <= n_len_done;
        end
    end

    // block buffer: byte lanes written in place, cleared after each compression
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || add_en) begin
            for (int i = 0; i < 16; i++) begin
                r_words[i] <= '0;
            end
        end else begin
            if (byte_we) begin
                r_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= byte_val;
            end
            if (len_we) begin
                r_words[LEN_WORD]    <= {r_cnt, 3'b000};
                r_words[LEN_HI_WORD] <= '0;
            end
        end
    end

    // chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load) begin
            r_ca <= CHAIN_A_INIT;
            r_cb <= CHAIN_B_INIT;
            r_cc <= CHAIN_C_INIT;
            r_cd <= CHAIN_D_INIT;
        end else if (add_en) begin
            r_ca <= r_ca + r_a;
            r_cb <= r_cb + r_b;
            r_cc <= r_cc + r_c;
            r_cd <= r_cd + r_d;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_a <= r_ca;
            r_b <= r_cb;
            r_c <= r_cc;
            r_d <= r_cd;
        end else if (r_state == ST_RUN) begin
            if (!r_ph) begin
                r_sum <= step_sum;
            end else begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= step_b;
            end
        end
    end

    md5hd_step u_step (
        .i_k   (r_k),
        .i_a   (r_a),
        .i_b   (r_b),
        .i_c   (r_c),
        .i_d   (r_d),
        .i_w   (r_words[msg_index(r_k)]),
        .i_sum (r_sum),
        .o_sum (step_sum),
        .o_b   (step_b)
    );

    md5hd_hex u_hex (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_digest (digest_order(r_ca, r_cb, r_cc, r_cd)),
        .o_busy   (hex_busy),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_char   (hex_char),
        .o_tlast  (o_m_axis_tlast)
    );

`include "md5_hex_digest_top_macros.svh"

    `MD5HD_ASSERT_NEXT(a_run_ends, (r_state == ST_RUN) && r_ph && (r_k == LAST_STEP), r_state == ST_ADD, "compression did not end after the last step")
    `MD5HD_ASSERT_NEXT(a_last_drains, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, !o_m_axis_tvalid, "digest output did not stop after last character")
    `MD5HD_ASSERT_NOW(a_no_take_final, r_last, !o_s_axis_tready, "byte accepted while a message is being finished")

endmodule
`default_nettype wire

// ===== verif/md5_hex_digest_top_test.sv =====
`timescale 1ns / 1ps

module md5_hex_digest_top_test;

    // Stop once this many bytes have been taken and the message in flight is complete.
    localparam int ITEM_TARGET    = 310;
    // Idle cycles (no item on either side) tolerated before the run is called hung.
    // The slowest legal gap is a final byte with pad overflow.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet time after the last digest, to catch stray output items.
    localparam int SETTLE_CYCLES  = 300;

    localparam logic [7:0] PAD_OCTET = 8'h80;

    // Per-step additive constants, floor(abs(sin(k + 1)) * 2^32).
    localparam logic [31:0] MIX_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left-rotate amounts, four per round.
    localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    typedef struct packed {
        logic [6:0] hex_char;
        logic       last_char;
    } t_digest_char;

    // Receiver back-pressure styles, re-chosen whenever rx_cycle[6:0] wraps to zero.
    typedef enum logic [1:0] {
        RX_ALWAYS,   // never stall
        RX_COIN,     // stall half the time at random
        RX_SPARSE,   // ready only when rx_cycle[1:0] is zero
        RX_MOSTLY    // stall one cycle in eight at random
    } t_rx_mode;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = 8'h00;
    logic       i_s_axis_tlast  = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;

    // Digest predictor plus the queue of hex characters still owed by the block.
    class digest_scoreboard;
        logic [31:0]  blk [16];
        logic [31:0]  ca, cb, cc, cd;
        logic [28:0]  n_bytes;
        t_digest_char owed_chars [$];
        int           errors;
        string        hex_digits;

        function new();
            hex_digits = "0123456789abcdef";
            errors     = 0;
            clear_message();
        endfunction

        function void clear_message();
            foreach (blk[i]) blk[i] = '0;
            ca      = 32'h67452301;
            cb      = 32'hefcdab89;
            cc      = 32'h98badcfe;
            cd      = 32'h10325476;
            n_bytes = '0;
        endfunction

        // Run the 64 steps over the buffer, fold into the chain, then empty the buffer.
        function void compress();
            logic [31:0] a, b, c, d, f, tmp;
            int          g;
            int          s;
            a = ca;
            b = cb;
            c = cc;
            d = cd;
            for (int k = 0; k < 64; k++) begin
                case (k / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = k;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = (5 * k + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * k + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * k) % 16;
                    end
                endcase
                tmp = a + f + blk[g] + MIX_K[k];
                s   = SHIFTS[(k / 16) * 4 + k % 4];
                a   = d;
                d   = c;
                c   = b;
                b   = b + ((tmp << s) | (tmp >> (32 - s)));
            end
            ca += a;
            cb += b;
            cc += c;
            cd += d;
            foreach (blk[i]) blk[i] = '0;
        endfunction

        function void place_octet(logic [5:0] pos, logic [7:0] v);
            blk[pos[5:2]] |= 32'(v) << (8 * pos[1:0]);
        endfunction

        // Account for one accepted message byte; a final byte queues the 32 characters.
        function void note_byte(logic [7:0] octet_in, logic fin);
            logic [5:0]   pos;
            logic [127:0] words;
            logic [7:0]   octet;
            pos = n_bytes[5:0];
            place_octet(pos, octet_in);
            n_bytes++;
            if (pos == 6'd63) compress();
            if (!fin) return;

            // Pad, spill to a fresh block if the length no longer fits, then close.
            pos = n_bytes[5:0];
            place_octet(pos, PAD_OCTET);
            if (pos >= 6'd56) compress();
            blk[14] = {n_bytes, 3'b000};
            blk[15] = '0;
            compress();

            words = {cd, cc, cb, ca};
            for (int i = 0; i < 16; i++) begin
                octet = words[8 * i +: 8];
                owed_chars.push_back(t_digest_char'{
                    hex_char: 7'(hex_digits[octet[7:4]]), last_char: 1'b0});
                owed_chars.push_back(t_digest_char'{
                    hex_char: 7'(hex_digits[octet[3:0]]), last_char: (i == 15)});
            end
            clear_message();
        endfunction

        function int pending();
            return owed_chars.size();
        endfunction

        function void check_char(logic [6:0] hex, logic last);
            t_digest_char want;
            if (owed_chars.size() == 0) begin
                $error("unexpected digest item: hex_char %h last_char %0b", hex, last);
                errors++;
                return;
            end
            want = owed_chars.pop_front();
            if (hex !== want.hex_char) begin
                $error("hex_char: expected %h, got %h", want.hex_char, hex);
                errors++;
            end
            if (last !== want.last_char) begin
                $error("last_char: expected %0b, got %0b", want.last_char, last);
                errors++;
            end
        endfunction
    endclass

    digest_scoreboard sb;

    int       burst_left  = 0;
    int       items_sent  = 0;
    int       idle_cycles = 0;
    int       msg_no      = 0;
    int       msg_len     = 0;
    logic [7:0] rx_cycle  = 8'd0;
    t_rx_mode rx_mode     = RX_ALWAYS;

    md5_hex_digest_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] msg_byte
        .i_s_axis_tlast  (i_s_axis_tlast),   // final_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [6:0] hex_char, [7] zero
        .o_m_axis_tlast  (o_m_axis_tlast)    // last_char
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one byte and hold it until taken; after a burst, drop valid for a random gap, possibly none.
    task automatic put_item(input logic [7:0] octet, input logic fin);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= octet;
        i_s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_byte(octet, fin);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Hold the sender off until every owed digest character has been taken.
    task automatic drain_digests();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: check each taken character, then choose readiness for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_char(o_m_axis_tdata[6:0], o_m_axis_tlast);
            end
            rx_cycle <= rx_cycle + 8'd1;
            if (rx_cycle[6:0] == 7'd0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_ALWAYS: i_m_axis_tready <= 1'b1;
                RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_m_axis_tready <= (rx_cycle[1:0] == 2'd0);
                default:   i_m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog: count cycles in which no item moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-byte messages 00, ff and 80, a short text, a mixed-bit run.
        put_item(8'h00, 1'b1);
        put_item(8'hff, 1'b1);
        put_item(8'h80, 1'b1);
        put_item(8'h61, 1'b0);
        put_item(8'h62, 1'b0);
        put_item(8'h63, 1'b1);
        put_item(8'h7f, 1'b0);
        put_item(8'h55, 1'b0);
        put_item(8'haa, 1'b0);
        put_item(8'h00, 1'b1);
        drain_digests();

        // Random messages: first pad overflow, an exactly full block and one byte short,
        // then mostly short messages with the odd one near a block boundary.
        while (items_sent < ITEM_TARGET) begin
            case (msg_no)
                0: msg_len = 56;
                1: msg_len = 64;
                2: msg_len = 63;
                default: begin
                    if ($urandom_range(0, 5) == 0) begin
                        case ($urandom_range(0, 2))
                            0:       msg_len = 55;
                            1:       msg_len = 57;
                            default: msg_len = 65;
                        endcase
                    end else begin
                        msg_len = $urandom_range(1, 20);
                    end
                end
            endcase
            for (int j = 0; j < msg_len; j++) begin
                put_item(8'($urandom_range(0, 255)), j == msg_len - 1);
            end
            if ($urandom_range(0, 7) == 0) drain_digests();
            msg_no++;
        end

        drain_digests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== md5_hex_digest_top.f =====
+incdir+rtl
rtl/md5hd_pkg.sv
rtl/md5hd_step.sv
rtl/md5hd_hex.sv
rtl/md5_hex_digest_top.sv
verif/md5_hex_digest_top_test.sv
